FILE: rtl/ct2d_pkg.sv
// Shared types, widths and helpers for the 2D trilateration block.
package ct2d_pkg;

  // Coordinate width and derived datapath widths
  localparam int CW     = 16;
  localparam int AB_W   = CW + 2;        // 2*(difference of coordinates)
  localparam int SQ_W   = 2 * CW;        // squares and sums of anchor squares
  localparam int C_W    = SQ_W + 2;      // C and F terms
  localparam int P_W    = C_W + AB_W;    // products C*E etc.
  localparam int NUM_W  = P_W + 1;       // numerators
  localparam int MAG_W  = NUM_W - 1;     // numerator magnitude
  localparam int DET_W  = 2 * AB_W;      // determinant
  localparam int DMAG_W = DET_W - 1;     // determinant magnitude
  localparam int Q_W    = CW + 1;        // quotient bits kept after the range check

  // Queues
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = OPTR_W + 1;

  localparam int CFG_IDX_W = 3;

  // Saturation limits
  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] POS_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3,
    REG_CX = 3'd4,
    REG_CY = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DET_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } anchors_t;

  // One classified solve between front and back
  typedef struct packed {
    logic signed [AB_W-1:0]  ka;
    logic signed [AB_W-1:0]  kb;
    logic signed [AB_W-1:0]  kd;
    logic signed [AB_W-1:0]  ke;
    logic signed [C_W-1:0]   kc;
    logic signed [C_W-1:0]   kf;
    logic signed [DET_W-1:0] det;
    logic                    det_zero;
  } mid_item_t;

  typedef struct packed {
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    status_t       status;
  } out_item_t;

  // 2*(b - a)
  function automatic logic signed [AB_W-1:0] diff2(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [AB_W-1:0] d;
    d = AB_W'(b) - AB_W'(a);
    return d <<< 1;
  endfunction

  // x^2 + y^2
  function automatic logic [SQ_W-1:0] sq_sum(input logic signed [CW-1:0] x,
                                             input logic signed [CW-1:0] y);
    logic signed [SQ_W-1:0] px;
    logic signed [SQ_W-1:0] py;
    px = x * x;
    py = y * y;
    return SQ_W'(unsigned'(px)) + SQ_W'(unsigned'(py));
  endfunction

endpackage

FILE: rtl/circle_trilateration_2d.sv
// Throughput: one range set per cycle while full is low; front (3 stages), queue, back (21 stages).
// The determinant divide is a restoring divider with one quotient bit per stage.
// Reset (synchronous, active low) empties both queues and the pipelines and
// sets all six anchor registers to zero.
module circle_trilateration_2d import ct2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [CW-1:0]        in_range_a,
  input  logic [CW-1:0]        in_range_b,
  input  logic [CW-1:0]        in_range_c,
  output logic                 empty,
  input  logic                 pop,
  output logic [CW-1:0]        out_pos_x,
  output logic [CW-1:0]        out_pos_y,
  output logic [1:0]           out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_wdata
);

  anchors_t          anchors_r;
  logic              take;
  logic [QCNT_W-1:0] inflight, q_count;
  logic              mid_push, mid_pop, mid_empty;
  mid_item_t         mid_item, mid_head;
  out_item_t         out_item;

  // Anchor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchors_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AX:  anchors_r.ax <= cfg_wdata;
        REG_AY:  anchors_r.ay <= cfg_wdata;
        REG_BX:  anchors_r.bx <= cfg_wdata;
        REG_BY:  anchors_r.by <= cfg_wdata;
        REG_CX:  anchors_r.cx <= cfg_wdata;
        REG_CY:  anchors_r.cy <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Room in the queue for everything the front still holds
  assign full = (q_count + inflight) >= QCNT_W'(QDEPTH);
  assign take = push && !full;

  ct2d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_range_a (in_range_a),
    .in_range_b (in_range_b),
    .in_range_c (in_range_c),
    .anchors    (anchors_r),
    .inflight   (inflight),
    .mid_push   (mid_push),
    .mid_item   (mid_item)
  );

  ct2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_item (mid_item),
    .pop       (mid_pop),
    .head      (mid_head),
    .empty     (mid_empty),
    .count     (q_count)
  );

  ct2d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_head  (mid_head),
    .mid_pop   (mid_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_item  (out_item)
  );

  assign out_pos_x  = out_item.pos_x;
  assign out_pos_y  = out_item.pos_y;
  assign out_status = out_item.status;

endmodule

FILE: rtl/ct2d_front.sv
// Front pipeline: squares, coefficients and determinant, with the zero check.
module ct2d_front import ct2d_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [CW-1:0]   in_range_a,
  input  logic [CW-1:0]   in_range_b,
  input  logic [CW-1:0]   in_range_c,
  input  anchors_t        anchors,
  output logic [QCNT_W-1:0] inflight,
  output logic            mid_push,
  output mid_item_t       mid_item
);

  logic                   v1_r, v2_r, v3_r;
  logic [SQ_W-1:0]        ra2_r, rb2_r, rc2_r, sa_r, sb_r, sc_r;
  logic signed [AB_W-1:0] ka1_r, kb1_r, kd1_r, ke1_r;
  logic signed [AB_W-1:0] ka2_r, kb2_r, kd2_r, ke2_r;
  logic signed [C_W-1:0]  kc2_r, kf2_r;
  logic signed [DET_W-1:0] ae2_r, bd2_r;
  mid_item_t              item3_r;
  logic signed [DET_W-1:0] det_nxt;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage 1: squares and coordinate differences
  always_ff @(posedge clk) begin
    ra2_r <= in_range_a * in_range_a;
    rb2_r <= in_range_b * in_range_b;
    rc2_r <= in_range_c * in_range_c;
    sa_r  <= sq_sum(anchors.ax, anchors.ay);
    sb_r  <= sq_sum(anchors.bx, anchors.by);
    sc_r  <= sq_sum(anchors.cx, anchors.cy);
    ka1_r <= diff2(anchors.ax, anchors.bx);
    kb1_r <= diff2(anchors.ay, anchors.by);
    kd1_r <= diff2(anchors.bx, anchors.cx);
    ke1_r <= diff2(anchors.by, anchors.cy);
  end

  // Stage 2: C, F and determinant products
  always_ff @(posedge clk) begin
    kc2_r <= C_W'(ra2_r) - C_W'(rb2_r) - C_W'(sa_r) + C_W'(sb_r);
    kf2_r <= C_W'(rb2_r) - C_W'(rc2_r) - C_W'(sb_r) + C_W'(sc_r);
    ae2_r <= ka1_r * ke1_r;
    bd2_r <= kb1_r * kd1_r;
    ka2_r <= ka1_r;
    kb2_r <= kb1_r;
    kd2_r <= kd1_r;
    ke2_r <= ke1_r;
  end

  // Stage 3: determinant and collinear check
  assign det_nxt = ae2_r - bd2_r;

  always_ff @(posedge clk) begin
    item3_r.ka       <= ka2_r;
    item3_r.kb       <= kb2_r;
    item3_r.kd       <= kd2_r;
    item3_r.ke       <= ke2_r;
    item3_r.kc       <= kc2_r;
    item3_r.kf       <= kf2_r;
    item3_r.det      <= det_nxt;
    item3_r.det_zero <= (det_nxt == '0);
  end

  assign mid_push = v3_r;
  assign mid_item = item3_r;
  assign inflight = QCNT_W'(v1_r) + QCNT_W'(v2_r) + QCNT_W'(v3_r);

endmodule

FILE: rtl/ct2d_queue.sv
// Short queue between front and back pipelines.
module ct2d_queue import ct2d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mid_item_t         push_item,
  input  logic              pop,
  output mid_item_t         head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  mid_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  assign head  = mem_r[rptr_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

FILE: rtl/ct2d_back.sv
// Back pipeline: numerators, restoring divide one quotient bit per stage, result queue.
module ct2d_back import ct2d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mid_empty,
  input  mid_item_t mid_head,
  output logic      mid_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic adv;

  // Stage b1: products
  logic                    v1_r;
  logic signed [P_W-1:0]   ce_r, fb_r, af_r, cd_r;
  logic signed [DET_W-1:0] det1_r;
  logic                    zero1_r;
  // Stage b2: numerators
  logic                    v2_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic signed [DET_W-1:0] det2_r;
  logic                    zero2_r;
  // Stage b3: magnitudes and signs
  logic                    v3_r;
  logic [MAG_W-1:0]        magx_r, magy_r;
  logic [DMAG_W-1:0]       dmag3_r;
  logic                    negx3_r, negy3_r, zero3_r;
  // Divide stages, index 0 holds the range check
  logic                    dv_r    [0:Q_W];
  logic [MAG_W-1:0]        remx_r  [0:Q_W];
  logic [MAG_W-1:0]        remy_r  [0:Q_W];
  logic [DMAG_W-1:0]       dmag_r  [0:Q_W];
  logic [Q_W-1:0]          qx_r    [0:Q_W];
  logic [Q_W-1:0]          qy_r    [0:Q_W];
  logic                    ovx_r   [0:Q_W];
  logic                    ovy_r   [0:Q_W];
  logic                    negx_r  [0:Q_W];
  logic                    negy_r  [0:Q_W];
  logic                    zero_r  [0:Q_W];
  logic [MAG_W-1:0]        remx_n  [1:Q_W];
  logic [MAG_W-1:0]        remy_n  [1:Q_W];
  logic [Q_W-1:0]          qx_n    [1:Q_W];
  logic [Q_W-1:0]          qy_n    [1:Q_W];
  logic [MAG_W-1:0]        dlim;

  // Result queue
  out_item_t         oq_r [ODEPTH];
  logic [OPTR_W-1:0] owptr_r, orptr_r;
  logic [OCNT_W-1:0] ocnt_r;
  logic              ofull, opush, opop;
  out_item_t         res;
  logic              satx, saty;

  // Whole pipeline holds only when its last stage cannot drain
  assign ofull   = (ocnt_r == OCNT_W'(ODEPTH));
  assign adv     = !(dv_r[Q_W] && ofull);
  assign mid_pop = !mid_empty && adv;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int i = 0; i <= Q_W; i++) dv_r[i] <= 1'b0;
    end else if (adv) begin
      v1_r <= mid_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      dv_r[0] <= v3_r;
      for (int i = 1; i <= Q_W; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  // Stages b1 to b3 and range check
  assign dlim = MAG_W'(dmag3_r) << Q_W;

  always_ff @(posedge clk) begin
    if (adv) begin
      ce_r    <= mid_head.kc * mid_head.ke;
      fb_r    <= mid_head.kf * mid_head.kb;
      af_r    <= mid_head.ka * mid_head.kf;
      cd_r    <= mid_head.kc * mid_head.kd;
      det1_r  <= mid_head.det;
      zero1_r <= mid_head.det_zero;

      nx_r    <= NUM_W'(ce_r) - NUM_W'(fb_r);
      ny_r    <= NUM_W'(af_r) - NUM_W'(cd_r);
      det2_r  <= det1_r;
      zero2_r <= zero1_r;

      magx_r  <= nx_r[NUM_W-1] ? MAG_W'(-nx_r) : MAG_W'(nx_r);
      magy_r  <= ny_r[NUM_W-1] ? MAG_W'(-ny_r) : MAG_W'(ny_r);
      dmag3_r <= det2_r[DET_W-1] ? DMAG_W'(-det2_r) : DMAG_W'(det2_r);
      negx3_r <= nx_r[NUM_W-1] ^ det2_r[DET_W-1];
      negy3_r <= ny_r[NUM_W-1] ^ det2_r[DET_W-1];
      zero3_r <= zero2_r;

      remx_r[0] <= magx_r;
      remy_r[0] <= magy_r;
      dmag_r[0] <= dmag3_r;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      ovx_r[0]  <= (magx_r >= dlim);
      ovy_r[0]  <= (magy_r >= dlim);
      negx_r[0] <= negx3_r;
      negy_r[0] <= negy3_r;
      zero_r[0] <= zero3_r;
    end
  end

  // One quotient bit per stage, most significant first
  always_comb begin
    for (int i = 1; i <= Q_W; i++) begin
      logic [MAG_W-1:0] sh;
      sh = MAG_W'(dmag_r[i-1]) << (Q_W - i);
      qx_n[i] = qx_r[i-1];
      qy_n[i] = qy_r[i-1];
      if (remx_r[i-1] >= sh) begin
        remx_n[i] = remx_r[i-1] - sh;
        qx_n[i][Q_W-i] = 1'b1;
      end else begin
        remx_n[i] = remx_r[i-1];
      end
      if (remy_r[i-1] >= sh) begin
        remy_n[i] = remy_r[i-1] - sh;
        qy_n[i][Q_W-i] = 1'b1;
      end else begin
        remy_n[i] = remy_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= Q_W; i++) begin
        remx_r[i] <= remx_n[i];
        remy_r[i] <= remy_n[i];
        qx_r[i]   <= qx_n[i];
        qy_r[i]   <= qy_n[i];
        dmag_r[i] <= dmag_r[i-1];
        ovx_r[i]  <= ovx_r[i-1];
        ovy_r[i]  <= ovy_r[i-1];
        negx_r[i] <= negx_r[i-1];
        negy_r[i] <= negy_r[i-1];
        zero_r[i] <= zero_r[i-1];
      end
    end
  end

  // Sign, saturation and status
  always_comb begin
    satx = ovx_r[Q_W] || (negx_r[Q_W] ? (qx_r[Q_W] > Q_W'(POS_MIN))
                                      : (qx_r[Q_W] > Q_W'(POS_MAX)));
    saty = ovy_r[Q_W] || (negy_r[Q_W] ? (qy_r[Q_W] > Q_W'(POS_MIN))
                                      : (qy_r[Q_W] > Q_W'(POS_MAX)));
    if (zero_r[Q_W]) begin
      res.pos_x  = '0;
      res.pos_y  = '0;
      res.status = ST_DET_ZERO;
    end else begin
      if (negx_r[Q_W]) res.pos_x = satx ? POS_MIN : CW'(-qx_r[Q_W]);
      else             res.pos_x = satx ? POS_MAX : CW'(qx_r[Q_W]);
      if (negy_r[Q_W]) res.pos_y = saty ? POS_MIN : CW'(-qy_r[Q_W]);
      else             res.pos_y = saty ? POS_MAX : CW'(qy_r[Q_W]);
      res.status = (satx || saty) ? ST_SAT : ST_OK;
    end
  end

  // Result queue
  assign opush = dv_r[Q_W] && adv;
  assign opop  = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (opush) owptr_r <= owptr_r + 1'b1;
      if (opop)  orptr_r <= orptr_r + 1'b1;
      ocnt_r <= ocnt_r + OCNT_W'(opush) - OCNT_W'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) oq_r[owptr_r] <= res;
  end

  assign out_empty = (ocnt_r == '0);
  assign out_item  = oq_r[orptr_r];

endmodule

FILE: rtl/ct2d_checker.sv
// Port-level checks for the trilateration block, bound to the top level.
module ct2d_checker import ct2d_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          empty,
  input logic          pop,
  input logic [CW-1:0] out_pos_x,
  input logic [CW-1:0] out_pos_y,
  input logic [1:0]    out_status
);

  // Reset flushes every pending result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results pending after reset");

  // Status stays within its defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status != 2'd3))
    else $error("undefined status code");

  // Collinear anchors give a zero position
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_DET_ZERO) |-> (out_pos_x == '0 && out_pos_y == '0))
    else $error("nonzero position with zero determinant");

  // Saturated status means one coordinate sits at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_SAT) |->
      (out_pos_x == POS_MAX || out_pos_x == POS_MIN ||
       out_pos_y == POS_MAX || out_pos_y == POS_MIN))
    else $error("saturated status without a saturated coordinate");

  // A waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pos_x) && $stable(out_pos_y)
                          && $stable(out_status)))
    else $error("waiting result changed");

endmodule

bind circle_trilateration_2d ct2d_checker u_ct2d_checker (.*);
